// ===== rtl/core/u2r_pkg.sv =====
// u2r_pkg: types and constants shared by the UYVY-to-RGB converter.
// No dependencies; imported by every module of the block.

package u2r_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CB_BLUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CR_RED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CB_GREEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CR_GREEN = 2'd3;

    // Reset weights, 1/256 units (1.772, 1.402, 0.344136, 0.714136)
    localparam logic [8:0] RST_CB_BLUE  = 9'd454;
    localparam logic [8:0] RST_CR_RED   = 9'd359;
    localparam logic [7:0] RST_CB_GREEN = 8'd88;
    localparam logic [7:0] RST_CR_GREEN = 8'd183;

    // Width of a floored chroma term (range -256..255)
    localparam int TERM_W = 10;

    // One UYVY macropixel
    typedef struct packed {
        logic [7:0] chroma_blue;
        logic [7:0] luma_first;
        logic [7:0] chroma_red;
        logic [7:0] luma_second;
    } t_uyvy;

    // Two RGB888 pixels
    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } t_rgb_pair;

    // Weight registers as seen by the datapath
    typedef struct packed {
        logic [8:0] cb_to_blue_weight;
        logic [8:0] cr_to_red_weight;
        logic [7:0] cb_to_green_weight;
        logic [7:0] cr_to_green_weight;
    } t_weights;

    // Floored chroma terms plus the two lumas, handed to the output stage
    typedef struct packed {
        logic [7:0]               luma_first;
        logic [7:0]               luma_second;
        logic signed [TERM_W-1:0] red_term;
        logic signed [TERM_W-1:0] green_term;
        logic signed [TERM_W-1:0] blue_term;
    } t_terms;

endpackage

// ===== rtl/core/u2r_chroma_terms.sv =====
// u2r_chroma_terms: three pipeline stages - chroma offset, weight
// multiplies, green sum and floor by 256. Depends on u2r_pkg.

module u2r_chroma_terms
    import u2r_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_weights i_weights,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_uyvy    i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_terms   o_terms
);

    // Stage valids and per-stage advance
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;

    // Stage 1: offset-binary chroma to signed (flip the top bit)
    logic signed [7:0] r_d1, r_e1;
    logic [7:0]        r_y0_1, r_y1_1;

    // Stage 2: exact products
    logic signed [17:0] r_pb2, r_pr2;
    logic signed [16:0] r_pgb2, r_pgr2;
    logic [7:0]         r_y0_2, r_y1_2;
    logic signed [17:0] n_pb2, n_pr2;
    logic signed [16:0] n_pgb2, n_pgr2;

    // Stage 3: floored terms
    t_terms             r_t3;
    logic signed [17:0] n_gsum;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_d1   <= $signed({~i_data.chroma_blue[7], i_data.chroma_blue[6:0]});
            r_e1   <= $signed({~i_data.chroma_red[7], i_data.chroma_red[6:0]});
            r_y0_1 <= i_data.luma_first;
            r_y1_1 <= i_data.luma_second;
        end
    end

    // Stage 2 multiplies: weights are unsigned, widened with a zero sign bit
    always_comb begin
        n_pb2  = $signed({1'b0, i_weights.cb_to_blue_weight}) * r_d1;
        n_pr2  = $signed({1'b0, i_weights.cr_to_red_weight}) * r_e1;
        n_pgb2 = $signed({1'b0, i_weights.cb_to_green_weight}) * r_d1;
        n_pgr2 = $signed({1'b0, i_weights.cr_to_green_weight}) * r_e1;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_pb2  <= n_pb2;
            r_pr2  <= n_pr2;
            r_pgb2 <= n_pgb2;
            r_pgr2 <= n_pgr2;
            r_y0_2 <= r_y0_1;
            r_y1_2 <= r_y1_1;
        end
    end

    // Stage 3: shared green sum; arithmetic shift is floor division by 256
    assign n_gsum = 18'(r_pgb2) + 18'(r_pgr2);

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_t3.luma_first  <= r_y0_2;
            r_t3.luma_second <= r_y1_2;
            r_t3.blue_term   <= r_pb2[17:8];
            r_t3.red_term    <= r_pr2[17:8];
            r_t3.green_term  <= n_gsum[17:8];
        end
    end

    assign o_terms = r_t3;

    // A stalled stage holds its item
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_ready |=> r_v3 && $stable(r_t3))
        else $error("stage 3 lost its item under stall");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !rdy3 |=> r_v2 && $stable(r_pb2) && $stable(r_pgr2))
        else $error("stage 2 lost its item under stall");

    // An accepted item always lands in stage 1
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted item not captured in stage 1");

endmodule

// ===== rtl/core/u2r_mix_sat.sv =====
// u2r_mix_sat: output stage - luma plus red/blue terms, minus green term,
// clamped to 0..255 into the result register. Depends on u2r_pkg.

module u2r_mix_sat
    import u2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_terms    i_terms,
    output logic      o_valid,
    input  logic      i_ready,
    output t_rgb_pair o_data
);

    // Clamp an 11-bit signed sum to 0..255
    function automatic logic [7:0] sat8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v[10])
            res = 8'd0;
        else if (v[9:8] != 2'b00)
            res = 8'hFF;
        else
            res = v[7:0];
        return res;
    endfunction

    logic              r_valid;
    t_rgb_pair         r_data;
    t_rgb_pair         n_data;
    logic signed [10:0] y0_s, y1_s, tr_s, tg_s, tb_s;

    assign o_ready = !r_valid || i_ready;

    // Sign-extend terms, zero-extend lumas
    always_comb begin
        y0_s = $signed({3'b000, i_terms.luma_first});
        y1_s = $signed({3'b000, i_terms.luma_second});
        tr_s = 11'(i_terms.red_term);
        tg_s = 11'(i_terms.green_term);
        tb_s = 11'(i_terms.blue_term);
        n_data.red_first    = sat8(y0_s + tr_s);
        n_data.green_first  = sat8(y0_s - tg_s);
        n_data.blue_first   = sat8(y0_s + tb_s);
        n_data.red_second   = sat8(y1_s + tr_s);
        n_data.green_second = sat8(y1_s - tg_s);
        n_data.blue_second  = sat8(y1_s + tb_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Both pixels share chroma, so channels are monotonic in luma together
    a_mono_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_data.red_first > r_data.red_second) |->
            r_data.green_first >= r_data.green_second &&
            r_data.blue_first >= r_data.blue_second)
        else $error("pixel channels not ordered with luma");

    a_mono_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_data.blue_first < r_data.blue_second) |->
            r_data.green_first <= r_data.green_second &&
            r_data.red_first <= r_data.red_second)
        else $error("pixel channels not ordered with luma");

    // A transfer in with room always produces a result next cycle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid)
        else $error("output stage dropped a transfer");

endmodule

// ===== rtl/core/uyvy_pair_to_rgb.sv =====
// uyvy_pair_to_rgb: top level - weight registers and the four-stage
// YCbCr 4:2:2 to RGB888 pipeline. Depends on u2r_pkg, u2r_chroma_terms, u2r_mix_sat.
//
//  channel   ports                                   direction
//  -------   -------------------------------------   ---------
//  input     i_in_valid / o_in_ready / i_in_data     UYVY macropixel in
//  output    o_out_valid / i_out_ready / o_out_data  two RGB pixels out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data       weight writes
//
// Four register stages: an accepted macropixel passes the stage 1, 2 and 3
// registers and then the output register, whose valid bit is o_out_valid. One
// macropixel is taken every cycle while the output is not stalled. Depth is set
// by the chroma offset, multiply, green sum/floor and add/clamp stages. A stall
// stops only the stages that are full, so bubbles are squeezed out. Synchronous
// active-low reset clears the valid bits and loads the default BT.601 weights.

module uyvy_pair_to_rgb
    import u2r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_uyvy                 i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rgb_pair             o_out_data
);

    t_weights r_weights;
    t_terms   terms;
    logic     terms_valid, terms_ready;

    // Weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.cb_to_blue_weight  <= RST_CB_BLUE;
            r_weights.cr_to_red_weight   <= RST_CR_RED;
            r_weights.cb_to_green_weight <= RST_CB_GREEN;
            r_weights.cr_to_green_weight <= RST_CR_GREEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CB_BLUE:  r_weights.cb_to_blue_weight  <= i_cfg_data;
                CFG_CR_RED:   r_weights.cr_to_red_weight   <= i_cfg_data;
                CFG_CB_GREEN: r_weights.cb_to_green_weight <= i_cfg_data[7:0];
                CFG_CR_GREEN: r_weights.cr_to_green_weight <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Stages 1-3: chroma terms
    u2r_chroma_terms u_terms (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_weights (r_weights),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .o_valid   (terms_valid),
        .i_ready   (terms_ready),
        .o_terms   (terms)
    );

    // Stage 4: add, clamp, output register
    u2r_mix_sat u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (terms_valid),
        .o_ready (terms_ready),
        .i_terms (terms),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
